// ----- rtl/rvd_pkg.sv -----
// ----------------------------------------------------------------------------
// rvd_pkg
// Shared types and codes for the RV32I instruction decoder: opcodes, funct
// codes, format and mnemonic codes, presence mask bits and stage structs.
// ----------------------------------------------------------------------------
package rvd_pkg;

    // major opcodes, instruction bits 6..0
    localparam logic [6:0] OP_REG    = 7'b0110011;
    localparam logic [6:0] OP_IMM    = 7'b0010011;
    localparam logic [6:0] OP_LOAD   = 7'b0000011;
    localparam logic [6:0] OP_JALR   = 7'b1100111;
    localparam logic [6:0] OP_SYSTEM = 7'b1110011;
    localparam logic [6:0] OP_STORE  = 7'b0100011;
    localparam logic [6:0] OP_BRANCH = 7'b1100011;
    localparam logic [6:0] OP_LUI    = 7'b0110111;
    localparam logic [6:0] OP_AUIPC  = 7'b0010111;
    localparam logic [6:0] OP_JAL    = 7'b1101111;

    // funct7 value that selects sub, sra and srai
    localparam logic [6:0] F7_ALT = 7'b0100000;

    // system funct12 values
    localparam logic [11:0] F12_ECALL  = 12'b000000000000;
    localparam logic [11:0] F12_EBREAK = 12'b000000000001;

    // funct3 codes, arithmetic groups
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // funct3 codes, loads and stores
    localparam logic [2:0] F3_BYTE   = 3'd0;
    localparam logic [2:0] F3_HALF   = 3'd1;
    localparam logic [2:0] F3_WORD   = 3'd2;
    localparam logic [2:0] F3_BYTE_U = 3'd4;
    localparam logic [2:0] F3_HALF_U = 3'd5;

    // funct3 codes, branches
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    // format codes
    localparam logic [2:0] FMT_R   = 3'd0;
    localparam logic [2:0] FMT_I   = 3'd1;
    localparam logic [2:0] FMT_S   = 3'd2;
    localparam logic [2:0] FMT_B   = 3'd3;
    localparam logic [2:0] FMT_U   = 3'd4;
    localparam logic [2:0] FMT_J   = 3'd5;
    localparam logic [2:0] FMT_BAD = 3'd6;

    // mnemonic codes
    localparam logic [5:0] MN_ADD    = 6'd0;
    localparam logic [5:0] MN_SUB    = 6'd1;
    localparam logic [5:0] MN_SLL    = 6'd2;
    localparam logic [5:0] MN_SLT    = 6'd3;
    localparam logic [5:0] MN_SLTU   = 6'd4;
    localparam logic [5:0] MN_XOR    = 6'd5;
    localparam logic [5:0] MN_SRL    = 6'd6;
    localparam logic [5:0] MN_SRA    = 6'd7;
    localparam logic [5:0] MN_OR     = 6'd8;
    localparam logic [5:0] MN_AND    = 6'd9;
    localparam logic [5:0] MN_ADDI   = 6'd10;
    localparam logic [5:0] MN_SLTI   = 6'd11;
    localparam logic [5:0] MN_SLTIU  = 6'd12;
    localparam logic [5:0] MN_XORI   = 6'd13;
    localparam logic [5:0] MN_ORI    = 6'd14;
    localparam logic [5:0] MN_ANDI   = 6'd15;
    localparam logic [5:0] MN_SLLI   = 6'd16;
    localparam logic [5:0] MN_SRLI   = 6'd17;
    localparam logic [5:0] MN_SRAI   = 6'd18;
    localparam logic [5:0] MN_LB     = 6'd19;
    localparam logic [5:0] MN_LH     = 6'd20;
    localparam logic [5:0] MN_LW     = 6'd21;
    localparam logic [5:0] MN_LBU    = 6'd22;
    localparam logic [5:0] MN_LHU    = 6'd23;
    localparam logic [5:0] MN_JALR   = 6'd24;
    localparam logic [5:0] MN_ECALL  = 6'd25;
    localparam logic [5:0] MN_EBREAK = 6'd26;
    localparam logic [5:0] MN_SB     = 6'd27;
    localparam logic [5:0] MN_SH     = 6'd28;
    localparam logic [5:0] MN_SW     = 6'd29;
    localparam logic [5:0] MN_BEQ    = 6'd30;
    localparam logic [5:0] MN_BNE    = 6'd31;
    localparam logic [5:0] MN_BLT    = 6'd32;
    localparam logic [5:0] MN_BGE    = 6'd33;
    localparam logic [5:0] MN_BLTU   = 6'd34;
    localparam logic [5:0] MN_BGEU   = 6'd35;
    localparam logic [5:0] MN_LUI    = 6'd36;
    localparam logic [5:0] MN_AUIPC  = 6'd37;
    localparam logic [5:0] MN_JAL    = 6'd38;
    localparam logic [5:0] MN_BAD    = 6'd39;

    // presence mask bit positions
    localparam int unsigned PB_RD  = 0;
    localparam int unsigned PB_RS1 = 1;
    localparam int unsigned PB_RS2 = 2;
    localparam int unsigned PB_F3  = 3;
    localparam int unsigned PB_F7  = 4;
    localparam int unsigned PB_IMM = 5;

    // presence masks per format
    localparam logic [5:0] MASK_R   = 6'b011111;
    localparam logic [5:0] MASK_I   = 6'b101011;
    localparam logic [5:0] MASK_SB  = 6'b101110;
    localparam logic [5:0] MASK_UJ  = 6'b100001;
    localparam logic [5:0] MASK_BAD = 6'b000000;

    // captured input item
    typedef struct packed {
        logic [31:0] word;
        logic [31:0] address;
    } fetch_t;

    // decoded result item
    typedef struct packed {
        logic [2:0]         format_code;
        logic [5:0]         mnemonic_code;
        logic [6:0]         opcode_bits;
        logic [4:0]         dest_reg;
        logic [4:0]         src_reg_a;
        logic [4:0]         src_reg_b;
        logic [2:0]         minor_op;
        logic [6:0]         major_op;
        logic signed [31:0] immediate;
        logic [5:0]         present_mask;
        logic [31:0]        out_address;
    } decode_t;

endpackage

// ----- rtl/rvd_in_stage.sv -----
// ----------------------------------------------------------------------------
// rvd_in_stage
// Input register of the decoder: captures instruction word and address and
// holds them while the result register ahead is blocked.
// ----------------------------------------------------------------------------
module rvd_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            valid,
    output logic            stall,
    input  logic [31:0]     instr_word,
    input  logic [31:0]     instr_address,
    output logic            held_valid,
    output rvd_pkg::fetch_t held,
    input  logic            advance
);
    import rvd_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    fetch_t data_reg;
    logic   load;

    // blocked only when holding an item that the next stage cannot take
    assign stall = valid_reg && !advance;
    assign load  = valid && !stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (!stall)
        begin
            valid_next = valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg.word    <= instr_word;
            data_reg.address <= instr_address;
        end
    end

    assign held_valid = valid_reg;
    assign held       = data_reg;

endmodule

// ----- rtl/rvd_decode.sv -----
// ----------------------------------------------------------------------------
// rvd_decode
// Combinational RV32I decode: format, mnemonic, field extraction and
// immediate assembly for one instruction word.
// ----------------------------------------------------------------------------
module rvd_decode (
    input  rvd_pkg::fetch_t  fetch,
    output rvd_pkg::decode_t result
);
    import rvd_pkg::*;

    logic [31:0] w;
    logic [6:0]  op;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [2:0]  fmt;
    logic [5:0]  mn;
    logic [5:0]  mask;
    logic [31:0] imm;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_u;
    logic [31:0] imm_j;
    logic        alt;

    assign w   = fetch.word;
    assign op  = w[6:0];
    assign f3  = w[14:12];
    assign f7  = w[31:25];
    assign alt = (f7 == F7_ALT);

    assign imm_i = {{20{w[31]}}, w[31:20]};
    assign imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
    assign imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    assign imm_u = {w[31:12], 12'b0};
    assign imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};

    always_comb
    begin
        fmt  = FMT_BAD;
        mn   = MN_BAD;
        mask = MASK_BAD;
        imm  = 32'b0;
        unique case (op)
            OP_REG:
            begin
                fmt  = FMT_R;
                mask = MASK_R;
                unique case (f3)
                    F3_ADD:  mn = alt ? MN_SUB : MN_ADD;
                    F3_SLL:  mn = MN_SLL;
                    F3_SLT:  mn = MN_SLT;
                    F3_SLTU: mn = MN_SLTU;
                    F3_XOR:  mn = MN_XOR;
                    F3_SR:   mn = alt ? MN_SRA : MN_SRL;
                    F3_OR:   mn = MN_OR;
                    F3_AND:  mn = MN_AND;
                    default: mn = MN_BAD;
                endcase
            end
            OP_IMM:
            begin
                fmt  = FMT_I;
                mask = MASK_I;
                imm  = imm_i;
                unique case (f3)
                    F3_ADD:  mn = MN_ADDI;
                    F3_SLL:  mn = MN_SLLI;
                    F3_SLT:  mn = MN_SLTI;
                    F3_SLTU: mn = MN_SLTIU;
                    F3_XOR:  mn = MN_XORI;
                    F3_SR:   mn = alt ? MN_SRAI : MN_SRLI;
                    F3_OR:   mn = MN_ORI;
                    F3_AND:  mn = MN_ANDI;
                    default: mn = MN_BAD;
                endcase
            end
            OP_LOAD:
            begin
                fmt  = FMT_I;
                mask = MASK_I;
                imm  = imm_i;
                unique case (f3)
                    F3_BYTE:   mn = MN_LB;
                    F3_HALF:   mn = MN_LH;
                    F3_WORD:   mn = MN_LW;
                    F3_BYTE_U: mn = MN_LBU;
                    F3_HALF_U: mn = MN_LHU;
                    default:   mn = MN_BAD;
                endcase
            end
            OP_JALR:
            begin
                fmt  = FMT_I;
                mask = MASK_I;
                imm  = imm_i;
                mn   = MN_JALR;
            end
            OP_SYSTEM:
            begin
                fmt  = FMT_I;
                mask = MASK_I;
                imm  = imm_i;
                priority if (w[31:20] == F12_ECALL)
                    mn = MN_ECALL;
                else if (w[31:20] == F12_EBREAK)
                    mn = MN_EBREAK;
                else
                    mn = MN_BAD;
            end
            OP_STORE:
            begin
                fmt  = FMT_S;
                mask = MASK_SB;
                imm  = imm_s;
                unique case (f3)
                    F3_BYTE: mn = MN_SB;
                    F3_HALF: mn = MN_SH;
                    F3_WORD: mn = MN_SW;
                    default: mn = MN_BAD;
                endcase
            end
            OP_BRANCH:
            begin
                fmt  = FMT_B;
                mask = MASK_SB;
                imm  = imm_b;
                unique case (f3)
                    F3_BEQ:  mn = MN_BEQ;
                    F3_BNE:  mn = MN_BNE;
                    F3_BLT:  mn = MN_BLT;
                    F3_BGE:  mn = MN_BGE;
                    F3_BLTU: mn = MN_BLTU;
                    F3_BGEU: mn = MN_BGEU;
                    default: mn = MN_BAD;
                endcase
            end
            OP_LUI:
            begin
                fmt  = FMT_U;
                mask = MASK_UJ;
                imm  = imm_u;
                mn   = MN_LUI;
            end
            OP_AUIPC:
            begin
                fmt  = FMT_U;
                mask = MASK_UJ;
                imm  = imm_u;
                mn   = MN_AUIPC;
            end
            OP_JAL:
            begin
                fmt  = FMT_J;
                mask = MASK_UJ;
                imm  = imm_j;
                mn   = MN_JAL;
            end
            default:
            begin
                fmt  = FMT_BAD;
                mn   = MN_BAD;
                mask = MASK_BAD;
                imm  = 32'b0;
            end
        endcase
    end

    // absent fields read as zero
    always_comb
    begin
        result.format_code   = fmt;
        result.mnemonic_code = mn;
        result.opcode_bits   = op;
        result.dest_reg      = mask[PB_RD]  ? w[11:7]  : 5'b0;
        result.src_reg_a     = mask[PB_RS1] ? w[19:15] : 5'b0;
        result.src_reg_b     = mask[PB_RS2] ? w[24:20] : 5'b0;
        result.minor_op      = mask[PB_F3]  ? f3       : 3'b0;
        result.major_op      = mask[PB_F7]  ? f7       : 7'b0;
        result.immediate     = mask[PB_IMM] ? $signed(imm) : 32'sd0;
        result.present_mask  = mask;
        result.out_address   = fetch.address;
    end

endmodule

// ----- rtl/rv32i_instruction_decoder.sv -----
// ----------------------------------------------------------------------------
// rv32i_instruction_decoder
// RV32I instruction decoder with registered input and registered result.
// ----------------------------------------------------------------------------
// One instruction is taken per cycle when not stalled; each gives exactly
// one result. The word is captured in the input register, decoded by
// combinational logic and stored in the result register. The two registers
// form a two-entry pipeline, so a new item is taken while a finished result
// waits for the downstream side; stall rises only when both registers are full
// and the result is held.
module rv32i_instruction_decoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        instr_word,
    input  logic [31:0]        instr_address,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         format_code,
    output logic [5:0]         mnemonic_code,
    output logic [6:0]         opcode_bits,
    output logic [4:0]         dest_reg,
    output logic [4:0]         src_reg_a,
    output logic [4:0]         src_reg_b,
    output logic [2:0]         minor_op,
    output logic [6:0]         major_op,
    output logic signed [31:0] immediate,
    output logic [5:0]         present_mask,
    output logic [31:0]        out_address
);
    import rvd_pkg::*;

    logic    held_valid;
    fetch_t  held;
    decode_t decoded;
    decode_t result_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    advance;

    // result register can take a new item unless it holds a stalled one
    assign advance = !(out_valid_reg && out_stall);

    rvd_in_stage u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .valid         (in_valid),
        .stall         (in_stall),
        .instr_word    (instr_word),
        .instr_address (instr_address),
        .held_valid    (held_valid),
        .held          (held),
        .advance       (advance)
    );

    rvd_decode u_decode (
        .fetch  (held),
        .result (decoded)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = held_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && held_valid)
        begin
            result_reg <= decoded;
        end
    end

    assign out_valid     = out_valid_reg;
    assign format_code   = result_reg.format_code;
    assign mnemonic_code = result_reg.mnemonic_code;
    assign opcode_bits   = result_reg.opcode_bits;
    assign dest_reg      = result_reg.dest_reg;
    assign src_reg_a     = result_reg.src_reg_a;
    assign src_reg_b     = result_reg.src_reg_b;
    assign minor_op      = result_reg.minor_op;
    assign major_op      = result_reg.major_op;
    assign immediate     = result_reg.immediate;
    assign present_mask  = result_reg.present_mask;
    assign out_address   = result_reg.out_address;

endmodule

// ----- rtl/rvd_checker.sv -----
// ----------------------------------------------------------------------------
// rvd_checker
// Port-level checks of the decoder's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module rvd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic [2:0]         format_code,
    input logic [5:0]         mnemonic_code,
    input logic [4:0]         dest_reg,
    input logic [4:0]         src_reg_a,
    input logic [4:0]         src_reg_b,
    input logic [2:0]         minor_op,
    input logic [6:0]         major_op,
    input logic signed [31:0] immediate,
    input logic [5:0]         present_mask
);
    import rvd_pkg::*;

    // a held result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // unknown opcode carries nothing
    a_bad: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && format_code == FMT_BAD |->
            present_mask == MASK_BAD && mnemonic_code == MN_BAD && immediate == 32'sd0)
        else $error("invalid opcode result not empty");

    // absent fields read as zero
    a_absent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            (present_mask[PB_RD]  || dest_reg == 5'b0) &&
            (present_mask[PB_RS1] || src_reg_a == 5'b0) &&
            (present_mask[PB_RS2] || src_reg_b == 5'b0) &&
            (present_mask[PB_F3]  || minor_op == 3'b0) &&
            (present_mask[PB_F7]  || major_op == 7'b0))
        else $error("absent field not zero");

    // funct7 only for register format
    a_f7: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && present_mask[PB_F7] |-> format_code == FMT_R)
        else $error("funct7 present outside R format");

    // branch and jump offsets are even
    a_even: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (format_code == FMT_B || format_code == FMT_J) |-> !immediate[0])
        else $error("odd branch or jump offset");

endmodule

bind rv32i_instruction_decoder rvd_checker u_rvd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .format_code   (format_code),
    .mnemonic_code (mnemonic_code),
    .dest_reg      (dest_reg),
    .src_reg_a     (src_reg_a),
    .src_reg_b     (src_reg_b),
    .minor_op      (minor_op),
    .major_op      (major_op),
    .immediate     (immediate),
    .present_mask  (present_mask)
);

// ----- tb/sv/tb_rv32i_instruction_decoder.sv -----
// ----------------------------------------------------------------------------
// tb_rv32i_instruction_decoder
// Self-checking bench for the RV32I decoder. A short table of hand-picked
// instruction words is followed by random words, mostly well-formed opcodes
// with random fields. Each accepted word is decoded by a local model or carries
// a typed expectation, and every result leaving the block is compared field by
// field, in order. Both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_rv32i_instruction_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import rvd_pkg::*;

    localparam int N_RANDOM = 1825;

    typedef struct {
        logic [31:0] word;
        logic [31:0] addr;
        bit          typed;
        decode_t     want;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [31:0]        instr_word;
    logic [31:0]        instr_address;
    logic               out_valid;
    logic               out_stall;
    logic [2:0]         format_code;
    logic [5:0]         mnemonic_code;
    logic [6:0]         opcode_bits;
    logic [4:0]         dest_reg;
    logic [4:0]         src_reg_a;
    logic [4:0]         src_reg_b;
    logic [2:0]         minor_op;
    logic [6:0]         major_op;
    logic signed [31:0] immediate;
    logic [5:0]         present_mask;
    logic [31:0]        out_address;

    // typed expectation travelling alongside the item on the input side
    bit        row_typed;
    decode_t   row_want;

    decode_t   pending[$];
    stim_row_t dir_rows[$];
    int        fail_count = 0;

    always #6 clk = ~clk;

    rv32i_instruction_decoder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .instr_word    (instr_word),
        .instr_address (instr_address),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .format_code   (format_code),
        .mnemonic_code (mnemonic_code),
        .opcode_bits   (opcode_bits),
        .dest_reg      (dest_reg),
        .src_reg_a     (src_reg_a),
        .src_reg_b     (src_reg_b),
        .minor_op      (minor_op),
        .major_op      (major_op),
        .immediate     (immediate),
        .present_mask  (present_mask),
        .out_address   (out_address)
    );

    function automatic decode_t decode_instr(input logic [31:0] w, input logic [31:0] addr);
        decode_t     d;
        logic [5:0]  mask;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [31:0] imm;
        f3 = w[14:12];
        f7 = w[31:25];
        d.format_code = FMT_BAD;
        d.mnemonic_code = MN_BAD;
        mask = MASK_BAD;
        imm = '0;
        case (w[6:0])
            OP_REG: begin
                d.format_code = FMT_R;
                mask = MASK_R;
                case (f3)
                    F3_ADD:  d.mnemonic_code = (f7 == F7_ALT) ? MN_SUB : MN_ADD;
                    F3_SLL:  d.mnemonic_code = MN_SLL;
                    F3_SLT:  d.mnemonic_code = MN_SLT;
                    F3_SLTU: d.mnemonic_code = MN_SLTU;
                    F3_XOR:  d.mnemonic_code = MN_XOR;
                    F3_SR:   d.mnemonic_code = (f7 == F7_ALT) ? MN_SRA : MN_SRL;
                    F3_OR:   d.mnemonic_code = MN_OR;
                    default: d.mnemonic_code = MN_AND;
                endcase
            end
            OP_IMM, OP_LOAD, OP_JALR, OP_SYSTEM: begin
                d.format_code = FMT_I;
                mask = MASK_I;
                imm = {{20{w[31]}}, w[31:20]};
                case (w[6:0])
                    OP_IMM: begin
                        case (f3)
                            F3_ADD:  d.mnemonic_code = MN_ADDI;
                            F3_SLL:  d.mnemonic_code = MN_SLLI;
                            F3_SLT:  d.mnemonic_code = MN_SLTI;
                            F3_SLTU: d.mnemonic_code = MN_SLTIU;
                            F3_XOR:  d.mnemonic_code = MN_XORI;
                            F3_SR:   d.mnemonic_code = (f7 == F7_ALT) ? MN_SRAI : MN_SRLI;
                            F3_OR:   d.mnemonic_code = MN_ORI;
                            default: d.mnemonic_code = MN_ANDI;
                        endcase
                    end
                    OP_LOAD: begin
                        case (f3)
                            F3_BYTE:   d.mnemonic_code = MN_LB;
                            F3_HALF:   d.mnemonic_code = MN_LH;
                            F3_WORD:   d.mnemonic_code = MN_LW;
                            F3_BYTE_U: d.mnemonic_code = MN_LBU;
                            F3_HALF_U: d.mnemonic_code = MN_LHU;
                            default:   d.mnemonic_code = MN_BAD;
                        endcase
                    end
                    OP_JALR: d.mnemonic_code = MN_JALR;
                    default: begin
                        if (w[31:20] == F12_ECALL)
                            d.mnemonic_code = MN_ECALL;
                        else if (w[31:20] == F12_EBREAK)
                            d.mnemonic_code = MN_EBREAK;
                        else
                            d.mnemonic_code = MN_BAD;
                    end
                endcase
            end
            OP_STORE: begin
                d.format_code = FMT_S;
                mask = MASK_SB;
                imm = {{20{w[31]}}, w[31:25], w[11:7]};
                case (f3)
                    F3_BYTE: d.mnemonic_code = MN_SB;
                    F3_HALF: d.mnemonic_code = MN_SH;
                    F3_WORD: d.mnemonic_code = MN_SW;
                    default: d.mnemonic_code = MN_BAD;
                endcase
            end
            OP_BRANCH: begin
                d.format_code = FMT_B;
                mask = MASK_SB;
                imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                case (f3)
                    F3_BEQ:  d.mnemonic_code = MN_BEQ;
                    F3_BNE:  d.mnemonic_code = MN_BNE;
                    F3_BLT:  d.mnemonic_code = MN_BLT;
                    F3_BGE:  d.mnemonic_code = MN_BGE;
                    F3_BLTU: d.mnemonic_code = MN_BLTU;
                    F3_BGEU: d.mnemonic_code = MN_BGEU;
                    default: d.mnemonic_code = MN_BAD;
                endcase
            end
            OP_LUI, OP_AUIPC: begin
                d.format_code = FMT_U;
                mask = MASK_UJ;
                imm = {w[31:12], 12'b0};
                d.mnemonic_code = (w[6:0] == OP_LUI) ? MN_LUI : MN_AUIPC;
            end
            OP_JAL: begin
                d.format_code = FMT_J;
                mask = MASK_UJ;
                imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
                d.mnemonic_code = MN_JAL;
            end
            default: ;
        endcase
        d.opcode_bits  = w[6:0];
        d.dest_reg     = mask[PB_RD]  ? w[11:7]  : '0;
        d.src_reg_a    = mask[PB_RS1] ? w[19:15] : '0;
        d.src_reg_b    = mask[PB_RS2] ? w[24:20] : '0;
        d.minor_op     = mask[PB_F3]  ? f3       : '0;
        d.major_op     = mask[PB_F7]  ? f7       : '0;
        d.immediate    = mask[PB_IMM] ? imm      : '0;
        d.present_mask = mask;
        d.out_address  = addr;
        return d;
    endfunction

    function automatic logic [31:0] mk_word(input logic [6:0] f7, input logic [4:0] rs2,
                                            input logic [4:0] rs1, input logic [2:0] f3,
                                            input logic [4:0] rd, input logic [6:0] op);
        return {f7, rs2, rs1, f3, rd, op};
    endfunction

    function automatic decode_t mk_decode(input logic [2:0] fmt, input logic [5:0] mn,
                                          input logic [6:0] op, input logic [4:0] rd,
                                          input logic [4:0] rs1, input logic [4:0] rs2,
                                          input logic [2:0] f3, input logic [6:0] f7,
                                          input logic [31:0] imm, input logic [5:0] mask,
                                          input logic [31:0] addr);
        decode_t d;
        d.format_code   = fmt;
        d.mnemonic_code = mn;
        d.opcode_bits   = op;
        d.dest_reg      = rd;
        d.src_reg_a     = rs1;
        d.src_reg_b     = rs2;
        d.minor_op      = f3;
        d.major_op      = f7;
        d.immediate     = imm;
        d.present_mask  = mask;
        d.out_address   = addr;
        return d;
    endfunction

    // mostly legal opcodes with random fields, some near misses and pure noise
    function automatic logic [31:0] rand_instr();
        logic [31:0] w;
        int          sel;
        w = $urandom();
        sel = $urandom_range(0, 99);
        if (sel < 85) begin
            case ($urandom_range(0, 9))
                0:       w[6:0] = OP_REG;
                1:       w[6:0] = OP_IMM;
                2:       w[6:0] = OP_LOAD;
                3:       w[6:0] = OP_JALR;
                4:       w[6:0] = OP_SYSTEM;
                5:       w[6:0] = OP_STORE;
                6:       w[6:0] = OP_BRANCH;
                7:       w[6:0] = OP_LUI;
                8:       w[6:0] = OP_AUIPC;
                default: w[6:0] = OP_JAL;
            endcase
            if ((w[6:0] == OP_REG || w[6:0] == OP_IMM) && $urandom_range(0, 1) == 1)
                w[31:25] = F7_ALT;
            if (w[6:0] == OP_SYSTEM) begin
                case ($urandom_range(0, 3))
                    0:       w[31:20] = F12_ECALL;
                    1:       w[31:20] = F12_EBREAK;
                    default: ;
                endcase
            end
        end else if (sel < 93) begin
            w[6:0] = ($urandom_range(0, 1) == 1 ? OP_REG : OP_JAL) ^ (7'd1 << $urandom_range(0, 6));
        end
        return w;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(15, 40);
    endfunction

    task automatic add_row(input logic [31:0] w, input logic [31:0] a, input bit typed,
                           input decode_t d);
        stim_row_t row;
        row.word  = w;
        row.addr  = a;
        row.typed = typed;
        row.want  = d;
        dir_rows.push_back(row);
    endtask

    task automatic send_item(input logic [31:0] w, input logic [31:0] a, input bit typed,
                             input decode_t d);
        in_valid      <= 1'b1;
        instr_word    <= w;
        instr_address <= a;
        row_typed     <= typed;
        row_want      <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // n must be at least one so valid is never lowered and raised in one step
    task automatic idle_sender(input int n);
        in_valid   <= 1'b0;
        instr_word <= $urandom();
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk) begin : scoreboard
        decode_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending.size() == 0) begin
                $error("result with no pending decode, out_address %0h", out_address);
                fail_count++;
            end else begin
                want = pending.pop_front();
                check_field("format_code", want.format_code, format_code);
                check_field("mnemonic_code", want.mnemonic_code, mnemonic_code);
                check_field("opcode_bits", want.opcode_bits, opcode_bits);
                check_field("dest_reg", want.dest_reg, dest_reg);
                check_field("src_reg_a", want.src_reg_a, src_reg_a);
                check_field("src_reg_b", want.src_reg_b, src_reg_b);
                check_field("minor_op", want.minor_op, minor_op);
                check_field("major_op", want.major_op, major_op);
                check_field("immediate", want.immediate, immediate);
                check_field("present_mask", want.present_mask, present_mask);
                check_field("out_address", want.out_address, out_address);
            end
        end
        if (rst_n && in_valid && !in_stall)
            pending.push_back(row_typed ? row_want : decode_instr(instr_word, instr_address));
    end

    // downstream stall pattern: long open stretches, short and long holds
    initial begin : rx_stall
        int r;
        int n;
        forever begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                out_stall <= 1'b0;
                n = $urandom_range(50, 200);
            end else if (r < 60) begin
                out_stall <= 1'b0;
                n = $urandom_range(1, 8);
            end else if (r < 95) begin
                out_stall <= 1'b1;
                n = $urandom_range(1, 3);
            end else begin
                out_stall <= 1'b1;
                n = $urandom_range(10, 40);
            end
            repeat (n) @(posedge clk);
        end
    end

    initial begin : watchdog
        #10000000;
        $display("tb_rv32i_instruction_decoder: FAIL");
        $finish;
    end

    initial begin : stimulus
        int          k;
        int          i;
        int          gap;
        bit          quiet;
        logic [31:0] a;
        decode_t     none;
        none = '0;
        quiet = 1'b0;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        instr_word    <= '0;
        instr_address <= '0;
        row_typed     <= 1'b0;
        row_want      <= '0;

        // unknown opcodes, both extremes of the word
        add_row(32'h0000_0000, 32'h0000_0000, 1'b1,
                mk_decode(FMT_BAD, MN_BAD, 7'h00, 5'd0, 5'd0, 5'd0, 3'd0, 7'd0,
                          32'd0, MASK_BAD, 32'h0000_0000));
        add_row(32'hffff_ffff, 32'hffff_ffff, 1'b1,
                mk_decode(FMT_BAD, MN_BAD, 7'h7f, 5'd0, 5'd0, 5'd0, 3'd0, 7'd0,
                          32'd0, MASK_BAD, 32'hffff_ffff));
        // system group: ecall, ebreak, unknown funct12
        add_row(mk_word(7'd0, 5'd0, 5'd0, F3_ADD, 5'd0, OP_SYSTEM), 32'h0000_0100, 1'b1,
                mk_decode(FMT_I, MN_ECALL, OP_SYSTEM, 5'd0, 5'd0, 5'd0, 3'd0, 7'd0,
                          32'd0, MASK_I, 32'h0000_0100));
        add_row({F12_EBREAK, 5'd0, F3_ADD, 5'd0, OP_SYSTEM}, 32'h0000_0104, 1'b1,
                mk_decode(FMT_I, MN_EBREAK, OP_SYSTEM, 5'd0, 5'd0, 5'd0, 3'd0, 7'd0,
                          32'd1, MASK_I, 32'h0000_0104));
        add_row({12'hfff, 5'd31, F3_ADD, 5'd31, OP_SYSTEM}, 32'h8000_0000, 1'b1,
                mk_decode(FMT_I, MN_BAD, OP_SYSTEM, 5'd31, 5'd31, 5'd0, 3'd0, 7'd0,
                          32'hffff_ffff, MASK_I, 32'h8000_0000));
        // register ops, including funct7 values other than the alternate one
        add_row(mk_word(7'h00, 5'd31, 5'd31, F3_ADD, 5'd31, OP_REG), $urandom(), 1'b0, none);
        add_row(mk_word(F7_ALT, 5'd3, 5'd2, F3_ADD, 5'd1, OP_REG), $urandom(), 1'b0, none);
        add_row(mk_word(7'h7f, 5'd3, 5'd2, F3_ADD, 5'd1, OP_REG), $urandom(), 1'b0, none);
        add_row(mk_word(F7_ALT, 5'd0, 5'd31, F3_SR, 5'd0, OP_REG), $urandom(), 1'b0, none);
        add_row(mk_word(7'h01, 5'd9, 5'd8, F3_SR, 5'd7, OP_REG), $urandom(), 1'b0, none);
        add_row(mk_word(F7_ALT, 5'd1, 5'd1, F3_AND, 5'd1, OP_REG), $urandom(), 1'b0, none);
        // immediate ops, shift variants and immediate extremes
        add_row(mk_word(F7_ALT, 5'd31, 5'd4, F3_SR, 5'd5, OP_IMM), $urandom(), 1'b0, none);
        add_row(mk_word(F7_ALT, 5'd7, 5'd4, F3_SLL, 5'd5, OP_IMM), $urandom(), 1'b0, none);
        add_row(mk_word(7'h40, 5'd0, 5'd31, F3_ADD, 5'd1, OP_IMM), $urandom(), 1'b0, none);
        add_row(mk_word(7'h3f, 5'd31, 5'd0, F3_ADD, 5'd0, OP_IMM), $urandom(), 1'b0, none);
        // loads and stores, including unused funct3
        add_row(mk_word(7'h00, 5'd8, 5'd2, F3_WORD, 5'd10, OP_LOAD), $urandom(), 1'b0, none);
        add_row(mk_word(7'h7f, 5'd31, 5'd1, F3_SLTU, 5'd3, OP_LOAD), $urandom(), 1'b0, none);
        add_row(mk_word(7'h7f, 5'd9, 5'd3, F3_WORD, 5'd31, OP_STORE), $urandom(), 1'b0, none);
        add_row(mk_word(7'h00, 5'd9, 5'd3, F3_AND, 5'd0, OP_STORE), $urandom(), 1'b0, none);
        // branches at both offset extremes and an unused funct3
        add_row(mk_word(7'h40, 5'd1, 5'd2, F3_BEQ, 5'd0, OP_BRANCH), $urandom(), 1'b0, none);
        add_row(mk_word(7'h3f, 5'd1, 5'd2, F3_BGEU, 5'd31, OP_BRANCH), $urandom(), 1'b0, none);
        add_row(mk_word(7'h15, 5'd6, 5'd7, F3_SLT, 5'd12, OP_BRANCH), $urandom(), 1'b0, none);
        // jalr with funct3 set, then upper immediates and jumps
        add_row(mk_word(7'h7f, 5'd31, 5'd1, F3_AND, 5'd1, OP_JALR), $urandom(), 1'b0, none);
        add_row(mk_word(7'h7f, 5'd31, 5'd31, F3_AND, 5'd0, OP_LUI), $urandom(), 1'b0, none);
        add_row(mk_word(7'h00, 5'd0, 5'd0, F3_ADD, 5'd7, OP_AUIPC), $urandom(), 1'b0, none);
        add_row(mk_word(7'h40, 5'd0, 5'd0, F3_ADD, 5'd1, OP_JAL), $urandom(), 1'b0, none);
        add_row(mk_word(7'h7f, 5'd31, 5'd31, F3_AND, 5'd31, OP_JAL), $urandom(), 1'b0, none);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < dir_rows.size(); k++) begin
            send_item(dir_rows[k].word, dir_rows[k].addr, dir_rows[k].typed, dir_rows[k].want);
            gap = pick_gap();
            if (gap > 0)
                idle_sender(gap);
        end
        wait_drained();

        for (i = 0; i < N_RANDOM; i++) begin
            // every so often a block of back-to-back items
            if (i % 100 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (i == N_RANDOM / 2)
                wait_drained();
            case ($urandom_range(0, 19))
                0:       a = 32'h0000_0000;
                1:       a = 32'hffff_ffff;
                default: a = $urandom();
            endcase
            send_item(rand_instr(), a, 1'b0, none);
            if (!quiet) begin
                gap = pick_gap();
                if (gap > 0)
                    idle_sender(gap);
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("tb_rv32i_instruction_decoder: PASS");
        else
            $display("tb_rv32i_instruction_decoder: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/rvd_pkg.sv
rtl/rvd_in_stage.sv
rtl/rvd_decode.sv
rtl/rv32i_instruction_decoder.sv
rtl/rvd_checker.sv
tb/sv/tb_rv32i_instruction_decoder.sv
